### design/dv_dif_timecode_rewriter_core_assert.svh
// assertion macros for the dv dif timecode rewriter
`ifndef DV_DIF_TIMECODE_REWRITER_CORE_ASSERT_SVH
`define DV_DIF_TIMECODE_REWRITER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DVTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DVTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dvtc_pkg.sv
// shared types and constants for the dv dif timecode rewriter
package dvtc_pkg;

  localparam int unsigned BLOCK_BYTES   = 80;
  localparam int unsigned SUBCODE_FIRST = 3;
  localparam int unsigned SUBCODE_LAST  = 66;

  localparam logic [7:0] SYNC_MARKER   = 8'hFF;
  localparam logic [7:0] PACK_TIMECODE = 8'h13;
  localparam logic [3:0] SYNC_ID_A     = 4'd3;
  localparam logic [3:0] SYNC_ID_B     = 4'd9;

  localparam logic [5:0] FPS_RESET = 6'd30;
  localparam logic [5:0] SEC_WRAP  = 6'd60;
  localparam logic [5:0] MIN_WRAP  = 6'd60;
  localparam logic [5:0] HOUR_WRAP = 6'd40;

  localparam logic [2:0] SECT_HEADER  = 3'd0;
  localparam logic [2:0] SECT_SUBCODE = 3'd1;

  // byte offset inside one 8-byte subcode sync block
  typedef enum logic [2:0] {
    SB_START,
    SB_ID,
    SB_MARKER,
    SB_PACK,
    SB_FRAMES,
    SB_SECONDS,
    SB_MINUTES,
    SB_HOURS
  } sb_off_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       block_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       rewritten;
    logic       block_last;
  } out_item_t;

  typedef struct packed {
    logic [5:0] frame;
    logic [5:0] second;
    logic [5:0] minute;
    logic [5:0] hour;
  } timecode_t;

endpackage

### design/dv_dif_timecode_rewriter_core.sv
// top level of the dv dif subcode timecode rewriter
//
// usage:
// - byte channel (byte_valid, byte_stall, byte_item) takes one stream byte
//   per item; block_start marks byte 0 of an 80-byte dif block, otherwise
//   the byte position free-runs 0..79
// - result channel (res_valid, res_stall, res_item) gives one item per input
//   item: the byte, unchanged or with a timecode pack byte patched in bcd,
//   a rewritten flag and a flag on byte 79
// - cfg channel (cfg_valid, cfg_ready, cfg_data) writes frames_per_second;
//   always ready, write only while no item is in flight
// result: res_valid rises in the cycle after an item is accepted
// throughput: one item per cycle while no waiting result is stalled, set by the single result register
// stall: while res_stall holds a waiting result, byte_stall is raised and
//   the result and all stream state hold
// reset: synchronous rst clears position, section, sequence and count
//   state, empties the result register and sets frames_per_second to 30
`include "dv_dif_timecode_rewriter_core_assert.svh"

module dv_dif_timecode_rewriter_core import dvtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  in_item_t   byte_item,
  output logic       res_valid,
  input  logic       res_stall,
  output out_item_t  res_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  // split a 0..63 value into bcd digits, tens by reciprocal multiply
  function automatic logic [7:0] bcd_of(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [5:0] units;
    prod  = {4'd0, v} * 10'd13;
    tens  = prod[9:7];
    units = v - ({3'd0, tens} * 6'd10);
    return {1'b0, tens, units[3:0]};
  endfunction

  // stream state
  logic [6:0] byte_position;
  logic [2:0] section_type;
  logic [3:0] previous_sequence;
  logic       sync_id_ok;
  logic       sync_marker_ok;
  logic       pack_matched;
  logic [5:0] frames_per_second;

  logic       accept;
  logic [6:0] pos;
  logic [6:0] byte_position_next;
  logic [2:0] section_type_next;
  logic [3:0] seq;
  logic       advance;
  logic       in_subcode;
  sb_off_t    off;
  logic       sync_id_ok_next;
  logic       sync_marker_ok_next;
  logic       pack_matched_next;
  out_item_t  res_next;
  timecode_t  tc;
  logic [7:0] digits;

  // result register frees up as soon as the receiver takes it
  assign byte_stall = res_valid && res_stall;
  assign accept     = byte_valid && !byte_stall;
  assign cfg_ready  = 1'b1;

  // block_start realigns to byte 0
  assign pos = byte_item.block_start ? 7'd0 : byte_position;
  assign byte_position_next = (pos == 7'(BLOCK_BYTES - 1)) ? 7'd0 : pos + 7'd1;
  assign section_type_next  = (pos == 7'd0) ? byte_item.in_byte[7:5] : section_type;
  assign seq = byte_item.in_byte[7:4];

  // header byte 1: a sequence number that does not grow starts a new frame
  assign advance = accept && (pos == 7'd1) && (section_type == SECT_HEADER)
                   && (seq <= previous_sequence);

  assign in_subcode = (section_type_next == SECT_SUBCODE)
                      && (pos >= 7'(SUBCODE_FIRST)) && (pos <= 7'(SUBCODE_LAST));
  assign off = sb_off_t'(pos[2:0] - 3'(SUBCODE_FIRST));

  dvtc_tc_counter u_counter (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .frames_per_second (frames_per_second),
    .tc                (tc)
  );

  // pick the count digit for the pack byte being passed
  always_comb begin
    unique case (off)
      SB_SECONDS: digits = bcd_of(tc.second);
      SB_MINUTES: digits = bcd_of(tc.minute);
      SB_HOURS:   digits = bcd_of(tc.hour);
      default:    digits = bcd_of(tc.frame);
    endcase
  end

  // sync block qualification and patching
  always_comb begin
    sync_id_ok_next     = sync_id_ok;
    sync_marker_ok_next = sync_marker_ok;
    pack_matched_next   = pack_matched;
    res_next.out_byte   = byte_item.in_byte;
    res_next.rewritten  = 1'b0;
    res_next.block_last = (pos == 7'(BLOCK_BYTES - 1));
    if (in_subcode) begin
      unique case (off)
        SB_START: begin
          sync_id_ok_next     = 1'b0;
          sync_marker_ok_next = 1'b0;
          pack_matched_next   = 1'b0;
        end
        SB_ID: begin
          sync_id_ok_next = (byte_item.in_byte[3:0] == SYNC_ID_A)
                            || (byte_item.in_byte[3:0] == SYNC_ID_B);
        end
        SB_MARKER: begin
          sync_marker_ok_next = (byte_item.in_byte == SYNC_MARKER);
        end
        SB_PACK: begin
          pack_matched_next = sync_id_ok && sync_marker_ok
                              && (byte_item.in_byte == PACK_TIMECODE);
        end
        SB_FRAMES, SB_HOURS: begin
          // keep bits 7..6, two-bit tens
          if (pack_matched) begin
            res_next.rewritten = 1'b1;
            res_next.out_byte  = {byte_item.in_byte[7:6], digits[5:0]};
          end
        end
        SB_SECONDS, SB_MINUTES: begin
          // keep bit 7, three-bit tens
          if (pack_matched) begin
            res_next.rewritten = 1'b1;
            res_next.out_byte  = {byte_item.in_byte[7], digits[6:0]};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      section_type      <= '0;
      previous_sequence <= '0;
      sync_id_ok        <= 1'b0;
      sync_marker_ok    <= 1'b0;
      pack_matched      <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (accept) begin
        byte_position  <= byte_position_next;
        section_type   <= section_type_next;
        sync_id_ok     <= sync_id_ok_next;
        sync_marker_ok <= sync_marker_ok_next;
        pack_matched   <= pack_matched_next;
        if ((pos == 7'd1) && (section_type == SECT_HEADER)) begin
          previous_sequence <= seq;
        end
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_item <= res_next;
    end
  end

  // frame rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_second <= FPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_per_second <= cfg_data;
    end
  end

  // accepted item always shows up in the result register next cycle
  `DVTC_ASSERT_NEXT(a_accept_gives_result, accept, res_valid, "accepted item lost")
  // a patched byte only comes from a qualified sync block
  `DVTC_ASSERT_NOW(a_rewrite_needs_match, res_valid && res_item.rewritten, pack_matched,
    "rewrite without matched pack")
  // last byte of a block leaves the position at zero
  `DVTC_ASSERT_NOW(a_last_wraps_position, res_valid && res_item.block_last,
    byte_position == 7'd0, "position did not wrap after byte 79")

endmodule

### design/dvtc_tc_counter.sv
// frame/second/minute/hour counter advanced once per new frame
module dvtc_tc_counter import dvtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [5:0] frames_per_second,
  output timecode_t  tc
);

  logic      count_started;
  timecode_t count;
  timecode_t count_next;
  logic [5:0] frame_inc;

  always_comb begin
    frame_inc  = count.frame + 6'd1;
    count_next = count;
    if (frame_inc >= frames_per_second) begin
      count_next.frame = '0;
      if (count.second + 6'd1 >= SEC_WRAP) begin
        count_next.second = '0;
        if (count.minute + 6'd1 >= MIN_WRAP) begin
          count_next.minute = '0;
          count_next.hour   = (count.hour + 6'd1 >= HOUR_WRAP) ? 6'd0 : count.hour + 6'd1;
        end else begin
          count_next.minute = count.minute + 6'd1;
        end
      end else begin
        count_next.second = count.second + 6'd1;
      end
    end else begin
      count_next.frame = frame_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_started <= 1'b0;
      count         <= '0;
    end else if (advance) begin
      // first new frame only arms the count
      count_started <= 1'b1;
      if (count_started) begin
        count <= count_next;
      end
    end
  end

  assign tc = count;

endmodule
